// ===== design/utx_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// utx_pkg
// Shared types and constants of the UTF-8 / UTF-16 transcoder.
// ----------------------------------------------------------------------------
package utx_pkg;

	localparam int CODE_W         = 21;
	localparam int QUEUE_DEPTH    = 4;
	localparam int QPTR_W         = $clog2(QUEUE_DEPTH);
	localparam int TOTAL_W        = 20;
	localparam int COUNT_BITS_DEF = 20;
	localparam int FMT_W          = 2;

	localparam logic [TOTAL_W-1:0] TOTAL_MAX = '1;

	localparam logic [FMT_W-1:0] FMT_UTF8  = 2'd0;
	localparam logic [FMT_W-1:0] FMT_U16BE = 2'd1;
	localparam logic [FMT_W-1:0] FMT_U16LE = 2'd2;

	localparam logic REG_IN_FMT  = 1'b0;
	localparam logic REG_OUT_FMT = 1'b1;

	typedef logic [CODE_W-1:0] code_t;

	typedef struct packed {
		logic  valid;
		code_t code;
	} chr_push_t;

	typedef struct packed {
		logic full;
		logic empty;
	} q_stat_t;

endpackage

// ===== design/unicode_utf8_utf16_transcoder.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// unicode_utf8_utf16_transcoder
// Streaming transcoder between UTF-8, UTF-16BE and UTF-16LE, one byte in
// and one byte out per transfer, with a character queue between decoder
// and encoder.
// ----------------------------------------------------------------------------
// channel   handshake            payload
// input     in_valid/in_ready    in_byte
// output    out_valid/out_ready  out_byte, last_of_char, string_end, bytes_total
// config    cfg_we               cfg_addr, cfg_wdata
//
// One input byte per cycle unless a replay runs or the queue is full; each character
// leaves as 1 to 4 bytes, one per cycle while out_ready is high, so the encoder output
// port sets the sustained rate. A bad UTF-8 sequence replays up to two held bytes, one
// per cycle while the queue has room, with in_ready low. Reset clears the control state
// and sets both formats to UTF-8. Output stalls back up through a four-entry character queue.
// ----------------------------------------------------------------------------
module unicode_utf8_utf16_transcoder import utx_pkg::*; #(
	parameter int COUNT_BITS = COUNT_BITS_DEF
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               cfg_we,
	input  logic               cfg_addr,
	input  logic [FMT_W-1:0]   cfg_wdata,
	input  logic               in_valid,
	output logic               in_ready,
	input  logic [7:0]         in_byte,
	output logic               out_valid,
	input  logic               out_ready,
	output logic [7:0]         out_byte,
	output logic               last_of_char,
	output logic               string_end,
	output logic [TOTAL_W-1:0] bytes_total
);

	chr_push_t q_push;
	q_stat_t   q_stat;
	code_t     q_head;
	logic      q_pop;

	utx_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_addr  (cfg_addr),
		.cfg_wdata (cfg_wdata),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.in_byte   (in_byte),
		.q_stat    (q_stat),
		.q_push    (q_push)
	);

	utx_fifo u_fifo (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (q_push),
		.pop    (q_pop),
		.head   (q_head),
		.stat   (q_stat)
	);

	utx_back #(
		.COUNT_BITS (COUNT_BITS)
	) u_back (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg_we       (cfg_we),
		.cfg_addr     (cfg_addr),
		.cfg_wdata    (cfg_wdata),
		.head         (q_head),
		.q_stat       (q_stat),
		.pop          (q_pop),
		.out_valid    (out_valid),
		.out_ready    (out_ready),
		.out_byte     (out_byte),
		.last_of_char (last_of_char),
		.string_end   (string_end),
		.bytes_total  (bytes_total)
	);

	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		q_push.valid |-> !q_stat.full)
		else $error("character queue overflow");

	a_no_underflow: assert property (@(posedge clk) disable iff (!arst_n)
		q_pop |-> !q_stat.empty)
		else $error("character queue underflow");

	a_end_shape: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && string_end) |-> (out_byte == 8'h00 && last_of_char))
		else $error("end result carries text");

endmodule

// ===== design/utx_front.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// utx_front
// Input decoder: takes one byte per transfer, collects UTF-8 sequences or
// UTF-16 units and surrogate pairs, and pushes finished character codes.
// ----------------------------------------------------------------------------
module utx_front import utx_pkg::*; (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             cfg_we,
	input  logic             cfg_addr,
	input  logic [FMT_W-1:0] cfg_wdata,
	input  logic             in_valid,
	output logic             in_ready,
	input  logic [7:0]       in_byte,
	input  q_stat_t          q_stat,
	output chr_push_t        q_push
);

	localparam logic [15:0] SURR_MASK = 16'hFC00;
	localparam logic [15:0] SURR_HIGH = 16'hD800;
	localparam code_t       SUPP_BASE = 21'h10000;

	function automatic logic [2:0] lead_len(input logic [7:0] b);
		logic [2:0] len;
		len = 3'd0;
		if ((b & 8'hF0) == 8'hE0) begin
			len = 3'd3;
		end else if ((b & 8'hE0) == 8'hC0) begin
			len = 3'd2;
		end else if ((b & 8'hF8) == 8'hF0) begin
			len = 3'd4;
		end
		return len;
	endfunction

	logic [FMT_W-1:0] in_fmt_q;
	logic [7:0]       held_q [3];
	logic [1:0]       hc_q;
	logic [2:0]       sl_q;
	logic [7:0]       rp_q [2];
	logic [1:0]       rp_cnt_q;
	logic [7:0]       first_q;
	logic             half_q;
	logic [9:0]       hsb_q;
	logic             pend_q;

	logic             replay;
	logic             is16;
	logic             go;
	logic [7:0]       x;

	logic [7:0]       n_held [3];
	logic [1:0]       n_hc;
	logic [2:0]       n_sl;
	logic [7:0]       n_rp [2];
	logic [1:0]       n_rpc;
	logic             u8_emit;
	code_t            u8_code;
	logic [2:0]       cnt;
	logic [2:0]       len;
	logic [7:0]       seq [4];
	logic             bad;

	logic [15:0]      unit;
	logic [7:0]       n_first;
	logic             n_half;
	logic [9:0]       n_hsb;
	logic             n_pend;
	logic             u16_emit;
	code_t            u16_code;

	assign replay   = rp_cnt_q != 2'd0;
	assign is16     = (in_fmt_q == FMT_U16BE) || (in_fmt_q == FMT_U16LE);
	assign in_ready = !replay && !q_stat.full;
	assign x        = replay ? rp_q[0] : in_byte;
	assign go       = !q_stat.full && (replay || in_valid);

	always_comb begin
		n_held  = held_q;
		n_hc    = hc_q;
		n_sl    = sl_q;
		n_rp    = rp_q;
		n_rpc   = rp_cnt_q;
		u8_emit = 1'b0;
		u8_code = '0;
		len     = lead_len(x);
		cnt     = {1'b0, hc_q} + 3'd1;
		seq[0]  = held_q[0];
		seq[1]  = (hc_q > 2'd1) ? held_q[1] : x;
		seq[2]  = (hc_q > 2'd2) ? held_q[2] : x;
		seq[3]  = x;
		bad     = 1'b0;
		for (int i = 1; i < 4; i++) begin
			if ((3'(i) < cnt) && (seq[i][7:6] != 2'b10)) begin
				bad = 1'b1;
			end
		end
		if (replay) begin
			n_rp[0] = rp_q[1];
			n_rpc   = rp_cnt_q - 2'd1;
		end
		if (hc_q == 2'd0) begin
			if (len == 3'd0) begin
				u8_emit = 1'b1;
				u8_code = CODE_W'(x);
			end else begin
				n_held[0] = x;
				n_hc      = 2'd1;
				n_sl      = len;
			end
		end else if ((cnt < sl_q) && (cnt < 3'd4)) begin
			n_held[hc_q] = x;
			n_hc         = cnt[1:0];
		end else begin
			n_hc    = 2'd0;
			n_sl    = 3'd0;
			u8_emit = 1'b1;
			if (bad) begin
				u8_code = CODE_W'({seq[0], seq[1]});
				n_rp[0] = seq[2];
				n_rp[1] = seq[3];
				n_rpc   = 2'(cnt - 3'd2);
			end else begin
				case (cnt)
					3'd2: u8_code = CODE_W'({seq[0][4:0], seq[1][5:0]});
					3'd3: u8_code = CODE_W'({seq[0][3:0], seq[1][5:0], seq[2][5:0]});
					default: u8_code = {seq[0][2:0], seq[1][5:0], seq[2][5:0], seq[3][5:0]};
				endcase
			end
		end
	end

	always_comb begin
		unit     = (in_fmt_q == FMT_U16BE) ? {first_q, x} : {x, first_q};
		n_first  = first_q;
		n_half   = half_q;
		n_hsb    = hsb_q;
		n_pend   = pend_q;
		u16_emit = 1'b0;
		u16_code = '0;
		if (!half_q) begin
			n_first = x;
			n_half  = 1'b1;
		end else begin
			n_half = 1'b0;
			if (pend_q) begin
				n_pend   = 1'b0;
				u16_emit = 1'b1;
				u16_code = SUPP_BASE + CODE_W'({hsb_q, unit[9:0]});
			end else if ((unit & SURR_MASK) == SURR_HIGH) begin
				n_hsb  = unit[9:0];
				n_pend = 1'b1;
			end else begin
				u16_emit = 1'b1;
				u16_code = CODE_W'(unit);
			end
		end
	end

	assign q_push.valid = go && (is16 ? u16_emit : u8_emit);
	assign q_push.code  = is16 ? u16_code : u8_code;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_fmt_q <= FMT_UTF8;
			held_q   <= '{default: '0};
			hc_q     <= '0;
			sl_q     <= '0;
			rp_q     <= '{default: '0};
			rp_cnt_q <= '0;
			first_q  <= '0;
			half_q   <= 1'b0;
			hsb_q    <= '0;
			pend_q   <= 1'b0;
		end else if (cfg_we && (cfg_addr == REG_IN_FMT)) begin
			in_fmt_q <= cfg_wdata;
			held_q   <= '{default: '0};
			hc_q     <= '0;
			sl_q     <= '0;
			rp_cnt_q <= '0;
			first_q  <= '0;
			half_q   <= 1'b0;
			hsb_q    <= '0;
			pend_q   <= 1'b0;
		end else if (go) begin
			if (is16) begin
				first_q <= n_first;
				half_q  <= n_half;
				hsb_q   <= n_hsb;
				pend_q  <= n_pend;
			end else begin
				held_q   <= n_held;
				hc_q     <= n_hc;
				sl_q     <= n_sl;
				rp_q     <= n_rp;
				rp_cnt_q <= n_rpc;
			end
		end
	end

endmodule

// ===== design/utx_fifo.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// utx_fifo
// Short character queue between the decoder and the encoder.
// ----------------------------------------------------------------------------
module utx_fifo import utx_pkg::*; (
	input  logic      clk,
	input  logic      arst_n,
	input  chr_push_t push,
	input  logic      pop,
	output code_t     head,
	output q_stat_t   stat
);

	code_t             mem_q [QUEUE_DEPTH];
	logic [QPTR_W-1:0] wptr_q;
	logic [QPTR_W-1:0] rptr_q;
	logic [QPTR_W:0]   cnt_q;

	always_ff @(posedge clk) begin
		if (push.valid) begin
			mem_q[wptr_q] <= push.code;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wptr_q <= '0;
			rptr_q <= '0;
			cnt_q  <= '0;
		end else begin
			if (push.valid) begin
				wptr_q <= wptr_q + 1'b1;
			end
			if (pop) begin
				rptr_q <= rptr_q + 1'b1;
			end
			cnt_q <= cnt_q + (QPTR_W+1)'(push.valid) - (QPTR_W+1)'(pop);
		end
	end

	assign head       = mem_q[rptr_q];
	assign stat.full  = cnt_q == (QPTR_W+1)'(QUEUE_DEPTH);
	assign stat.empty = cnt_q == '0;

endmodule

// ===== design/utx_back.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// utx_back
// Output encoder: turns the queued character into UTF-8 or UTF-16 bytes,
// one per cycle while out_ready is high, and keeps the saturating byte count of the string.
// ----------------------------------------------------------------------------
module utx_back import utx_pkg::*; #(
	parameter int COUNT_BITS = COUNT_BITS_DEF
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               cfg_we,
	input  logic               cfg_addr,
	input  logic [FMT_W-1:0]   cfg_wdata,
	input  code_t              head,
	input  q_stat_t            q_stat,
	output logic               pop,
	output logic               out_valid,
	input  logic               out_ready,
	output logic [7:0]         out_byte,
	output logic               last_of_char,
	output logic               string_end,
	output logic [TOTAL_W-1:0] bytes_total
);

	localparam int EXT_W = (COUNT_BITS > TOTAL_W) ? COUNT_BITS : TOTAL_W;

	function automatic logic [TOTAL_W-1:0] cnt_report(input logic [COUNT_BITS-1:0] c);
		logic [EXT_W-1:0] e;
		e = EXT_W'(c);
		return (e > EXT_W'(TOTAL_MAX)) ? TOTAL_MAX : e[TOTAL_W-1:0];
	endfunction

	logic [FMT_W-1:0]      out_fmt_q;
	logic [1:0]            idx_q;
	logic [COUNT_BITS-1:0] cnt_q;
	logic                  out_valid_q;
	logic [7:0]            out_byte_q;
	logic                  last_q;
	logic                  end_q;
	logic [TOTAL_W-1:0]    total_q;

	logic                  is16;
	logic                  le;
	logic                  is_end;
	logic [2:0]            nb;
	logic [7:0]            bseq [4];
	logic [15:0]           u;
	code_t                 sub;
	logic [15:0]           hs;
	logic [15:0]           ls;
	logic                  last;
	logic                  load;
	logic [COUNT_BITS-1:0] inc;

	assign is16   = (out_fmt_q == FMT_U16BE) || (out_fmt_q == FMT_U16LE);
	assign le     = out_fmt_q == FMT_U16LE;
	assign is_end = head == '0;
	assign sub    = head - CODE_W'(21'h10000);
	assign hs     = {6'b110110, sub[19:10]};
	assign ls     = {6'b110111, head[9:0]};

	always_comb begin
		nb   = 3'd1;
		bseq = '{default: 8'h00};
		u    = head[15:0];
		if (is_end) begin
			nb = 3'd1;
		end else if (is16) begin
			if (head[20:16] == 5'd0) begin
				nb = 3'd2;
			end else begin
				nb = 3'd4;
				u  = idx_q[1] ? ls : hs;
			end
			bseq[idx_q] = (idx_q[0] ^ le) ? u[7:0] : u[15:8];
		end else if (head <= CODE_W'(21'h7F)) begin
			nb      = 3'd1;
			bseq[0] = head[7:0];
		end else if (head <= CODE_W'(21'h7FF)) begin
			nb      = 3'd2;
			bseq[0] = {3'b110, head[10:6]};
			bseq[1] = {2'b10, head[5:0]};
		end else if (head <= CODE_W'(21'hFFFF)) begin
			nb      = 3'd3;
			bseq[0] = {4'b1110, head[15:12]};
			bseq[1] = {2'b10, head[11:6]};
			bseq[2] = {2'b10, head[5:0]};
		end else begin
			nb      = 3'd4;
			bseq[0] = {5'b11110, head[20:18]};
			bseq[1] = {2'b10, head[17:12]};
			bseq[2] = {2'b10, head[11:6]};
			bseq[3] = {2'b10, head[5:0]};
		end
	end

	assign last = ({1'b0, idx_q} + 3'd1) == nb;
	assign load = !q_stat.empty && (!out_valid_q || out_ready);
	assign pop  = load && last;
	assign inc  = (cnt_q != '1) ? cnt_q + 1'b1 : cnt_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_fmt_q   <= FMT_UTF8;
			idx_q       <= '0;
			cnt_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (cfg_we && (cfg_addr == REG_OUT_FMT)) begin
				out_fmt_q <= cfg_wdata;
			end
			if (load) begin
				out_valid_q <= 1'b1;
				idx_q       <= last ? 2'd0 : idx_q + 2'd1;
				cnt_q       <= is_end ? '0 : inc;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			out_byte_q <= bseq[idx_q];
			last_q     <= last;
			end_q      <= is_end;
			total_q    <= is_end ? cnt_report(cnt_q) : cnt_report(inc);
		end
	end

	assign out_valid    = out_valid_q;
	assign out_byte     = out_byte_q;
	assign last_of_char = last_q;
	assign string_end   = end_q;
	assign bytes_total  = total_q;

endmodule
